// ----- design/assert_macros.svh -----
// assertion macros used by the sequencer core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define NBMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define NBMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/nbms_pkg.sv -----
// package for the nine-bit bus master sequencer
// beat types, operation and status codes, parameter defaults; no dependencies
`timescale 1ns / 1ps

package nbms_pkg;

    localparam int MAX_BYTES_DEF    = 64;
    localparam int TICKS_PER_MS_DEF = 10;

    localparam logic [8:0]  ADDR_FLAG  = 9'h100;
    localparam logic [15:0] TICKS_SAT  = 16'hFFFF;

    localparam logic [3:0] OP_LOAD     = 4'd0;
    localparam logic [3:0] OP_ADDRESS  = 4'd1;
    localparam logic [3:0] OP_TRANSFER = 4'd2;
    localparam logic [3:0] OP_ABORT    = 4'd3;
    localparam logic [3:0] OP_RX_BYTE  = 4'd4;
    localparam logic [3:0] OP_TX_EMPTY = 4'd5;
    localparam logic [3:0] OP_SR_EMPTY = 4'd6;
    localparam logic [3:0] OP_OVERRUN  = 4'd7;
    localparam logic [3:0] OP_TICK     = 4'd8;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_LOST      = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;
    localparam logic [2:0] ST_COLLISION = 3'd5;

    typedef struct packed {
        logic [3:0]  operation;
        logic [7:0]  slave_address;
        logic [12:0] timeout_ms;
        logic [6:0]  tx_length;
        logic [6:0]  rx_length;
        logic [5:0]  buffer_index;
        logic [8:0]  data_word;
    } t_cmd;

    typedef struct packed {
        logic       accepted;
        logic       tx_valid;
        logic [8:0] tx_word;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [5:0] rx_index;
        logic [2:0] status;
        logic       drive_enable;
    } t_rsp;

endpackage

// ----- design/nbms_chan_if.sv -----
// valid/ready channel carrying one beat of a given payload type
// no dependencies
`timescale 1ns / 1ps

interface nbms_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/nine_bit_bus_master_sequencer.sv -----
// Master sequencer for a 9-bit multidrop UART bus. Every command or line event
// beat on i_cmd yields exactly one result beat on o_rsp, in order. A beat is
// registered on entry in r_in, handled by combinational logic and registered
// again in r_out, from which its result is offered on o_rsp; a stalled o_rsp
// holds the beat in r_in. One beat per cycle is taken sustained while o_rsp
// does not stall; a stalled o_rsp holds at most one input beat plus one
// result. The tx buffer is a MAX_BYTES x 8 memory whose read port is
// addressed one beat ahead at the next byte position, with write bypass, so
// loads while busy are seen by the very next transmit-ready event.
// depends on nbms_pkg, nbms_chan_if, nbms_txbuf and nbms_core
`timescale 1ns / 1ps

module nine_bit_bus_master_sequencer #(
    parameter int MAX_BYTES    = nbms_pkg::MAX_BYTES_DEF,
    parameter int TICKS_PER_MS = nbms_pkg::TICKS_PER_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbms_chan_if.sink   i_cmd,
    nbms_chan_if.source o_rsp
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    nbms_core #(
        .MAX_BYTES    (MAX_BYTES),
        .TICKS_PER_MS (TICKS_PER_MS),
        .AW           (AW),
        .CW           (CW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    nbms_txbuf #(
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_txbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ----- design/nbms_txbuf.sv -----
// tx byte buffer: one write port, one registered read port with write bypass
// no package dependencies
`timescale 1ns / 1ps

module nbms_txbuf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/nbms_core.sv -----
// sequencer core: input register, phase/state update, result register
// depends on nbms_pkg, nbms_chan_if and assert_macros.svh
`timescale 1ns / 1ps

module nbms_core #(
    parameter int MAX_BYTES    = nbms_pkg::MAX_BYTES_DEF,
    parameter int TICKS_PER_MS = nbms_pkg::TICKS_PER_MS_DEF,
    parameter int AW           = 6,
    parameter int CW           = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nbms_chan_if.sink     i_cmd,
    nbms_chan_if.source   o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);

    `include "assert_macros.svh"

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SEND_ADDR = 3'd1;
    localparam logic [2:0] PH_RECV_ADDR = 3'd2;
    localparam logic [2:0] PH_SEND_DATA = 3'd3;
    localparam logic [2:0] PH_RECV_DATA = 3'd4;

    logic             r_in_v;
    nbms_pkg::t_cmd   r_in;
    logic             r_out_v;
    nbms_pkg::t_rsp   r_out;
    logic             advance;

    logic [2:0]    r_phase,    n_phase;
    logic [2:0]    r_status,   n_status;
    logic [CW-1:0] r_byte_pos, n_byte_pos;
    logic [CW-1:0] r_send_cnt, n_send_cnt;
    logic [CW-1:0] r_recv_cnt, n_recv_cnt;
    logic [7:0]    r_target,   n_target;
    logic [15:0]   r_limit,    n_limit;
    logic [15:0]   r_ticks,    n_ticks;
    logic          r_line_dir, n_line_dir;

    nbms_pkg::t_rsp rsp;
    logic [CW-1:0]  tx_len, rx_len;
    logic [31:0]    tick_prod;
    logic [15:0]    limit_new;
    logic [15:0]    ticks_inc;
    logic [CW-1:0]  pos_inc;
    logic [CW+5:0]  pos_ext;
    logic [AW+5:0]  idx_ext;

    assign advance     = r_in_v && (!r_out_v || o_rsp.ready);
    assign i_cmd.ready = !r_in_v || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.payload;
        end
    end

    // command decode helpers
    always_comb begin
        tx_len = (32'(r_in.tx_length) > MAX_BYTES) ? CW'(MAX_BYTES) : CW'(r_in.tx_length);
        rx_len = (32'(r_in.rx_length) > MAX_BYTES) ? CW'(MAX_BYTES) : CW'(r_in.rx_length);
        tick_prod = 32'(r_in.timeout_ms) * 32'(TICKS_PER_MS);
        limit_new = (tick_prod > 32'(nbms_pkg::TICKS_SAT)) ? nbms_pkg::TICKS_SAT
                                                           : tick_prod[15:0];
        ticks_inc = r_ticks + 16'd1;
        pos_inc   = r_byte_pos + CW'(1);
        pos_ext   = (CW+6)'(r_byte_pos);
        idx_ext   = (AW+6)'(r_in.buffer_index);
    end

    always_comb begin
        n_phase    = r_phase;
        n_status   = r_status;
        n_byte_pos = r_byte_pos;
        n_send_cnt = r_send_cnt;
        n_recv_cnt = r_recv_cnt;
        n_target   = r_target;
        n_limit    = r_limit;
        n_ticks    = r_ticks;
        n_line_dir = r_line_dir;
        rsp          = '0;
        rsp.accepted = 1'b1;
        o_wr_en      = 1'b0;
        o_wr_addr    = idx_ext[AW-1:0];
        o_wr_data    = r_in.data_word[7:0];
        if (advance) begin
            unique case (r_in.operation)
                nbms_pkg::OP_LOAD: begin
                    o_wr_en = (32'(r_in.buffer_index) < MAX_BYTES);
                end
                nbms_pkg::OP_ADDRESS: begin
                    if (r_phase != PH_IDLE) begin
                        rsp.accepted = 1'b0;
                    end else begin
                        n_target     = r_in.slave_address;
                        n_limit      = limit_new;
                        n_phase      = PH_SEND_ADDR;
                        n_line_dir   = 1'b1;
                        n_status     = nbms_pkg::ST_BUSY;
                        rsp.tx_valid = 1'b1;
                        rsp.tx_word  = {1'b0, r_in.slave_address} | nbms_pkg::ADDR_FLAG;
                    end
                end
                nbms_pkg::OP_TRANSFER: begin
                    if (r_phase != PH_IDLE) begin
                        rsp.accepted = 1'b0;
                    end else begin
                        n_send_cnt = tx_len;
                        n_recv_cnt = rx_len;
                        n_limit    = limit_new;
                        if (tx_len != '0) begin
                            n_phase    = PH_SEND_DATA;
                            n_line_dir = 1'b1;
                            n_status   = nbms_pkg::ST_BUSY;
                            n_byte_pos = '0;
                        end else if (rx_len != '0) begin
                            n_phase    = PH_RECV_DATA;
                            n_line_dir = 1'b0;
                            n_status   = nbms_pkg::ST_BUSY;
                            n_byte_pos = '0;
                            n_ticks    = '0;
                        end
                    end
                end
                nbms_pkg::OP_ABORT: begin
                    n_phase    = PH_IDLE;
                    n_line_dir = 1'b0;
                    n_status   = nbms_pkg::ST_IDLE;
                end
                nbms_pkg::OP_RX_BYTE: begin
                    if (r_phase == PH_RECV_ADDR) begin
                        n_phase    = PH_IDLE;
                        n_line_dir = 1'b0;
                        n_status   = (r_in.data_word == ({1'b0, r_target} | nbms_pkg::ADDR_FLAG))
                                     ? nbms_pkg::ST_IDLE : nbms_pkg::ST_MISMATCH;
                    end else if (r_phase == PH_RECV_DATA) begin
                        if (r_in.data_word[8]) begin
                            n_phase    = PH_IDLE;
                            n_line_dir = 1'b0;
                            n_status   = nbms_pkg::ST_COLLISION;
                        end else begin
                            rsp.rx_valid = 1'b1;
                            rsp.rx_data  = r_in.data_word[7:0];
                            rsp.rx_index = pos_ext[5:0];
                            n_byte_pos   = pos_inc;
                            if (pos_inc >= r_recv_cnt) begin
                                n_phase    = PH_IDLE;
                                n_line_dir = 1'b0;
                                n_status   = nbms_pkg::ST_IDLE;
                            end
                        end
                    end
                end
                nbms_pkg::OP_TX_EMPTY, nbms_pkg::OP_SR_EMPTY: begin
                    if (r_phase == PH_SEND_ADDR) begin
                        if (r_in.operation == nbms_pkg::OP_SR_EMPTY) begin
                            n_phase    = PH_RECV_ADDR;
                            n_line_dir = 1'b0;
                            n_ticks    = '0;
                        end
                    end else if (r_phase == PH_SEND_DATA) begin
                        if (r_byte_pos < r_send_cnt) begin
                            rsp.tx_valid = 1'b1;
                            rsp.tx_word  = (32'(r_byte_pos) < MAX_BYTES)
                                           ? {1'b0, i_rd_data} : 9'd0;
                            n_byte_pos   = pos_inc;
                        end else if (r_in.operation == nbms_pkg::OP_SR_EMPTY) begin
                            if (r_recv_cnt != '0) begin
                                n_phase    = PH_RECV_DATA;
                                n_line_dir = 1'b0;
                                n_status   = nbms_pkg::ST_BUSY;
                                n_byte_pos = '0;
                                n_ticks    = '0;
                            end else begin
                                n_phase    = PH_IDLE;
                                n_line_dir = 1'b0;
                                n_status   = nbms_pkg::ST_IDLE;
                            end
                        end
                    end
                end
                nbms_pkg::OP_OVERRUN: begin
                    if (r_phase == PH_RECV_ADDR || r_phase == PH_RECV_DATA) begin
                        n_phase    = PH_IDLE;
                        n_line_dir = 1'b0;
                        n_status   = nbms_pkg::ST_LOST;
                    end
                end
                nbms_pkg::OP_TICK: begin
                    if ((r_phase == PH_RECV_ADDR || r_phase == PH_RECV_DATA)
                            && r_limit != '0) begin
                        n_ticks = ticks_inc;
                        if (ticks_inc >= r_limit) begin
                            n_phase    = PH_IDLE;
                            n_line_dir = 1'b0;
                            n_status   = nbms_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: begin
                    rsp.accepted = 1'b0;
                end
            endcase
        end
        rsp.status       = n_status;
        rsp.drive_enable = n_line_dir;
    end

    // buffer is read one beat ahead at the next byte position
    assign o_rd_addr = n_byte_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_status   <= nbms_pkg::ST_IDLE;
            r_byte_pos <= '0;
            r_send_cnt <= '0;
            r_recv_cnt <= '0;
            r_target   <= '0;
            r_limit    <= '0;
            r_ticks    <= '0;
            r_line_dir <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_byte_pos <= n_byte_pos;
            r_send_cnt <= n_send_cnt;
            r_recv_cnt <= n_recv_cnt;
            r_target   <= n_target;
            r_limit    <= n_limit;
            r_ticks    <= n_ticks;
            r_line_dir <= n_line_dir;
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_out;

    `NBMS_ASSERT(a_busy_iff_active, i_clk, i_rst_n,
        (r_phase != PH_IDLE) == (r_status == nbms_pkg::ST_BUSY), "status/phase disagree")
    `NBMS_ASSERT_IMPL(a_drive_only_sending, i_clk, i_rst_n, r_line_dir,
        (r_phase == PH_SEND_ADDR || r_phase == PH_SEND_DATA), "line driven outside send")
    `NBMS_ASSERT_IMPL(a_rx_only_in_data, i_clk, i_rst_n, advance && rsp.rx_valid,
        (r_phase == PH_RECV_DATA) && (32'(r_byte_pos) < MAX_BYTES), "rx beat out of phase")

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for nine_bit_bus_master_sequencer: a scoreboard class predicts every result beat
// from the command and event beats it is given; plain tasks drive the command channel
// depends on nbms_pkg, nbms_chan_if and nine_bit_bus_master_sequencer
`timescale 1ns / 1ps

package nbms_tb_pkg;
    import nbms_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND_ADDR,
        PH_RECV_ADDR,
        PH_SEND_DATA,
        PH_RECV_DATA
    } t_bus_phase;

    localparam int BUF_DEPTH = MAX_BYTES_DEF;
    localparam int MAX_PRINTED = 50;

    localparam logic [3:0] OP_FIRST_UNDEF = 4'd9;
    localparam logic [3:0] OP_LAST_UNDEF  = 4'd15;

    class rsp_scoreboard;
        t_bus_phase  ph;
        logic [2:0]  stat;
        logic [6:0]  pos;
        logic [6:0]  send_cnt;
        logic [6:0]  recv_cnt;
        logic [7:0]  target;
        logic [15:0] tmo_limit;
        logic [15:0] tick_cnt;
        logic [7:0]  tx_mem [BUF_DEPTH];
        logic        drive;
        t_rsp        awaited_rsp [$];
        int          errors;
        int          checked;

        function new();
            ph        = PH_IDLE;
            stat      = ST_IDLE;
            pos       = '0;
            send_cnt  = '0;
            recv_cnt  = '0;
            target    = '0;
            tmo_limit = '0;
            tick_cnt  = '0;
            drive     = 1'b0;
            errors    = 0;
            checked   = 0;
            foreach (tx_mem[i]) tx_mem[i] = '0;
        endfunction

        function void go_idle(logic [2:0] s);
            ph    = PH_IDLE;
            drive = 1'b0;
            stat  = s;
        endfunction

        function void enter_recv();
            ph       = PH_RECV_DATA;
            drive    = 1'b0;
            stat     = ST_BUSY;
            pos      = '0;
            tick_cnt = '0;
        endfunction

        function logic [6:0] clamp_len(logic [6:0] v);
            return (v > BUF_DEPTH) ? 7'(BUF_DEPTH) : v;
        endfunction

        function void load_timeout(logic [12:0] ms);
            int t;
            t = int'(ms) * TICKS_PER_MS_DEF;
            tmo_limit = (t > int'(TICKS_SAT)) ? TICKS_SAT : 16'(t);
        endfunction

        function t_rsp next_response(t_cmd c);
            t_rsp r;
            r = '0;
            r.accepted = 1'b1;
            case (c.operation)
                OP_LOAD: begin
                    if (int'(c.buffer_index) < BUF_DEPTH) tx_mem[c.buffer_index] = c.data_word[7:0];
                end
                OP_ADDRESS: begin
                    if (ph != PH_IDLE) begin
                        r.accepted = 1'b0;
                    end else begin
                        target = c.slave_address;
                        load_timeout(c.timeout_ms);
                        ph         = PH_SEND_ADDR;
                        drive      = 1'b1;
                        stat       = ST_BUSY;
                        r.tx_valid = 1'b1;
                        r.tx_word  = ADDR_FLAG | {1'b0, target};
                    end
                end
                OP_TRANSFER: begin
                    if (ph != PH_IDLE) begin
                        r.accepted = 1'b0;
                    end else begin
                        send_cnt = clamp_len(c.tx_length);
                        recv_cnt = clamp_len(c.rx_length);
                        load_timeout(c.timeout_ms);
                        if (send_cnt != 0) begin
                            ph    = PH_SEND_DATA;
                            drive = 1'b1;
                            stat  = ST_BUSY;
                            pos   = '0;
                        end else if (recv_cnt != 0) begin
                            enter_recv();
                        end
                    end
                end
                OP_ABORT: go_idle(ST_IDLE);
                OP_RX_BYTE: begin
                    if (ph == PH_RECV_ADDR) begin
                        go_idle((c.data_word == (ADDR_FLAG | {1'b0, target})) ?
                                ST_IDLE : ST_MISMATCH);
                    end else if (ph == PH_RECV_DATA) begin
                        if (c.data_word[8]) begin
                            go_idle(ST_COLLISION);
                        end else begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = c.data_word[7:0];
                            r.rx_index = pos[5:0];
                            pos++;
                            if (pos >= recv_cnt) go_idle(ST_IDLE);
                        end
                    end
                end
                OP_TX_EMPTY, OP_SR_EMPTY: begin
                    if (ph == PH_SEND_ADDR) begin
                        if (c.operation == OP_SR_EMPTY) begin
                            ph       = PH_RECV_ADDR;
                            drive    = 1'b0;
                            tick_cnt = '0;
                        end
                    end else if (ph == PH_SEND_DATA) begin
                        if (pos < send_cnt) begin
                            r.tx_valid = 1'b1;
                            r.tx_word  = {1'b0, tx_mem[pos[5:0]]};
                            pos++;
                        end else if (c.operation == OP_SR_EMPTY) begin
                            if (recv_cnt != 0) enter_recv();
                            else go_idle(ST_IDLE);
                        end
                    end
                end
                OP_OVERRUN: begin
                    if (ph == PH_RECV_ADDR || ph == PH_RECV_DATA) go_idle(ST_LOST);
                end
                OP_TICK: begin
                    if ((ph == PH_RECV_ADDR || ph == PH_RECV_DATA) && tmo_limit != 0) begin
                        tick_cnt++;
                        if (tick_cnt >= tmo_limit) go_idle(ST_TIMEOUT);
                    end
                end
                default: r.accepted = 1'b0;
            endcase
            r.status       = stat;
            r.drive_enable = drive;
            return r;
        endfunction

        function void note_command(t_cmd c);
            awaited_rsp.push_back(next_response(c));
        endfunction

        task report(string field, int got, int want);
            if (errors < MAX_PRINTED)
                $display("result %0d: %s got 0x%0h want 0x%0h", checked, field, got, want);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            checked++;
            if (awaited_rsp.size() == 0) begin
                report("beat with nothing pending", 0, 0);
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
            if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_word !== want.tx_word) report("tx_word", got.tx_word, want.tx_word);
            if (got.rx_valid !== want.rx_valid) report("rx_valid", got.rx_valid, want.rx_valid);
            if (got.rx_data !== want.rx_data) report("rx_data", got.rx_data, want.rx_data);
            if (got.rx_index !== want.rx_index) report("rx_index", got.rx_index, want.rx_index);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.drive_enable !== want.drive_enable)
                report("drive_enable", got.drive_enable, want.drive_enable);
        endtask
    endclass

endpackage

module testbench;
    import nbms_pkg::*;
    import nbms_tb_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    nbms_chan_if #(.T(t_cmd)) cmd_ch ();
    nbms_chan_if #(.T(t_rsp)) rsp_ch ();

    nine_bit_bus_master_sequencer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    rsp_scoreboard        sb = new();
    t_cmd                 plan [$];
    bit [BUF_DEPTH-1:0]   loaded;
    int                   burst_left;
    int                   sent;
    int                   cycle_ct;
    int                   stall_mode;
    int                   stall_left;
    int                   stall_ct;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_ct++;
        if (cycle_ct > CYCLE_LIMIT) begin
            $display("nine_bit_bus_master_sequencer: mismatch");
            $finish;
        end
    end

    // result side: check accepted beats, stall on a changing pattern
    always @(posedge i_clk) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) sb.check_response(rsp_ch.payload);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_ct++;
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (stall_ct % 5 != 0);
        endcase
    end

    function automatic t_cmd any_cmd(logic [3:0] op);
        t_cmd c;
        c.operation     = op;
        c.slave_address = 8'($urandom);
        c.timeout_ms    = 13'($urandom);
        c.tx_length     = 7'($urandom);
        c.rx_length     = 7'($urandom);
        c.buffer_index  = 6'($urandom);
        c.data_word     = 9'($urandom);
        return c;
    endfunction

    // a transfer only ever sends buffer entries that were loaded beforehand
    function automatic void queue_cmd(t_cmd c);
        t_cmd fill;
        int   n;
        if (c.operation == OP_TRANSFER) begin
            n = (c.tx_length > BUF_DEPTH) ? BUF_DEPTH : int'(c.tx_length);
            for (int i = 0; i < n; i++) begin
                if (!loaded[i]) begin
                    fill = any_cmd(OP_LOAD);
                    fill.buffer_index = 6'(i);
                    loaded[i] = 1'b1;
                    plan.push_back(fill);
                end
            end
        end
        if (c.operation == OP_LOAD) loaded[c.buffer_index] = 1'b1;
        plan.push_back(c);
    endfunction

    function automatic logic [12:0] pick_timeout();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 13'd0;
            4, 5, 6: return 13'd1;
            7: return 13'd2;
            8: return 13'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic void directed_plan();
        t_cmd c;
        queue_cmd(any_cmd(OP_TICK));
        queue_cmd(any_cmd(OP_RX_BYTE));
        queue_cmd(any_cmd(OP_FIRST_UNDEF));
        c = any_cmd(OP_LOAD); c.buffer_index = 6'd0;  c.data_word = 9'h1FF; queue_cmd(c);
        c = any_cmd(OP_LOAD); c.buffer_index = 6'd63; c.data_word = 9'h000; queue_cmd(c);
        c = any_cmd(OP_LOAD); c.buffer_index = 6'd1;  c.data_word = 9'h0A5; queue_cmd(c);
        // empty transfer keeps idle
        c = any_cmd(OP_TRANSFER);
        c.tx_length = '0; c.rx_length = '0; c.timeout_ms = '1;
        queue_cmd(c);
        // saturated timeout, commands refused while busy
        c = any_cmd(OP_ADDRESS); c.slave_address = 8'hFF; c.timeout_ms = '1; queue_cmd(c);
        queue_cmd(any_cmd(OP_ADDRESS));
        c = any_cmd(OP_TRANSFER); c.tx_length = 7'd2; queue_cmd(c);
        queue_cmd(any_cmd(OP_TX_EMPTY));
        queue_cmd(any_cmd(OP_SR_EMPTY));
        queue_cmd(any_cmd(OP_TICK));
        c = any_cmd(OP_RX_BYTE); c.data_word = 9'h1FF; queue_cmd(c);
        // echo without the address flag
        c = any_cmd(OP_ADDRESS); c.slave_address = 8'h00; c.timeout_ms = '0; queue_cmd(c);
        queue_cmd(any_cmd(OP_SR_EMPTY));
        c = any_cmd(OP_RX_BYTE); c.data_word = 9'h000; queue_cmd(c);
        // two bytes out, oversized receive length, then a collision
        c = any_cmd(OP_TRANSFER);
        c.tx_length = 7'd2; c.rx_length = 7'h7F; c.timeout_ms = '0;
        queue_cmd(c);
        queue_cmd(any_cmd(OP_TX_EMPTY));
        queue_cmd(any_cmd(OP_SR_EMPTY));
        queue_cmd(any_cmd(OP_SR_EMPTY));
        c = any_cmd(OP_RX_BYTE); c.data_word = 9'h0FF; queue_cmd(c);
        c = any_cmd(OP_RX_BYTE); c.data_word = 9'h100; queue_cmd(c);
        // receive only, overrun, then abort clears the status
        c = any_cmd(OP_TRANSFER); c.tx_length = '0; c.rx_length = 7'd1; queue_cmd(c);
        queue_cmd(any_cmd(OP_OVERRUN));
        queue_cmd(any_cmd(OP_ABORT));
        queue_cmd(any_cmd(OP_LAST_UNDEF));
    endfunction

    function automatic void address_sequence();
        t_cmd       c;
        logic [7:0] a;
        int         n;
        a = 8'($urandom);
        c = any_cmd(OP_ADDRESS);
        c.slave_address = a;
        c.timeout_ms    = pick_timeout();
        queue_cmd(c);
        repeat ($urandom_range(0, 2)) queue_cmd(any_cmd(OP_TX_EMPTY));
        if ($urandom_range(0, 9) == 0) begin
            queue_cmd(any_cmd(OP_ABORT));
            return;
        end
        queue_cmd(any_cmd(OP_SR_EMPTY));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
        repeat (n) queue_cmd(any_cmd(OP_TICK));
        c = any_cmd(OP_RX_BYTE);
        case ($urandom_range(0, 9))
            0: c.operation = OP_OVERRUN;
            1: ;
            2: c.data_word = {1'b0, a};
            3: c.data_word = {1'b1, a ^ 8'(1 << $urandom_range(0, 7))};
            default: c.data_word = ADDR_FLAG | {1'b0, a};
        endcase
        queue_cmd(c);
    endfunction

    function automatic void transfer_sequence();
        t_cmd c;
        int   ntx;
        int   nrx;
        c = any_cmd(OP_TRANSFER);
        c.tx_length = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(60, 127))
                                                   : 7'($urandom_range(0, 6));
        c.rx_length = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(60, 127))
                                                   : 7'($urandom_range(0, 8));
        c.timeout_ms = (c.rx_length > 20) ? 13'd0 : pick_timeout();
        ntx = (c.tx_length > BUF_DEPTH) ? BUF_DEPTH : int'(c.tx_length);
        nrx = (c.rx_length > BUF_DEPTH) ? BUF_DEPTH : int'(c.rx_length);
        queue_cmd(c);
        for (int i = 0; i < ntx; i++) begin
            if ($urandom_range(0, 9) == 0) queue_cmd(any_cmd(OP_LOAD));
            if ($urandom_range(0, 29) == 0) begin
                queue_cmd(any_cmd(OP_ABORT));
                return;
            end
            queue_cmd(any_cmd($urandom_range(0, 1) ? OP_TX_EMPTY : OP_SR_EMPTY));
        end
        if (ntx > 0) begin
            repeat ($urandom_range(0, 1)) queue_cmd(any_cmd(OP_TX_EMPTY));
            queue_cmd(any_cmd(OP_SR_EMPTY));
        end
        for (int i = 0; i < nrx; i++) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) queue_cmd(any_cmd(OP_TICK));
            c = any_cmd(OP_RX_BYTE);
            case ($urandom_range(0, 49))
                0: begin
                    c.data_word[8] = 1'b1;
                    queue_cmd(c);
                    return;
                end
                1: begin
                    queue_cmd(any_cmd(OP_OVERRUN));
                    return;
                end
                2: begin
                    queue_cmd(any_cmd(OP_ABORT));
                    return;
                end
                default: begin
                    c.data_word[8] = 1'b0;
                    queue_cmd(c);
                end
            endcase
        end
    endfunction

    task automatic send_beat(t_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        sb.note_command(c);
        sent++;
    endtask

    task automatic run_plan();
        while (plan.size() != 0) send_beat(plan.pop_front());
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.awaited_rsp.size() != 0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_plan();
        run_plan();
        wait_drained();

        while (sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: transfer_sequence();
                9, 10, 11, 12, 13, 14, 15: address_sequence();
                default: repeat ($urandom_range(1, 4)) queue_cmd(any_cmd(4'($urandom)));
            endcase
            run_plan();
            if ($urandom_range(0, 59) == 0) wait_drained();
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("nine_bit_bus_master_sequencer: match");
        end else begin
            $display("nine_bit_bus_master_sequencer: mismatch");
        end
        $finish;
    end

endmodule
